// File: sv/ebz_pkg.sv
// Shared field widths and types for the extended GCD block.
package ebz_pkg;

    localparam int IN_W    = 31;
    localparam int COEFF_W = 32;
    localparam int GCD_W   = 31;

    typedef logic [IN_W-1:0]    operand_t;
    typedef logic [COEFF_W-1:0] coeff_t;
    typedef logic [GCD_W-1:0]   gcd_t;

endpackage

// File: sv/ebz_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module ebz_div #(
    parameter int W = 31
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quot_reg;
    logic [W-1:0]  dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [W:0]    shifted;
    logic [W:0]    trial;

    assign shifted = {rem_reg, quot_reg[W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            // trial MSB set means the subtraction went negative: restore
            if (!trial[W])
            begin
                rem_reg  <= trial[W-1:0];
                quot_reg <= {quot_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted[W-1:0];
                quot_reg <= {quot_reg[W-2:0], 1'b0};
            end
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// File: sv/extended_gcd_bezout_top.sv
// Extended GCD: Bezout coefficients and gcd of two operands, forward iteration.
// Each Euclid step runs a test, the bit-serial divider, a divider-done check,
// two multiplies and the update; there are up to about 46 steps for 31-bit operands.
// One request at a time; the next is taken once the result is in the output register.
// Reset (rst_n, async low) returns the sequencer to idle and drops the output valid.
module extended_gcd_bezout_top
    import ebz_pkg::*;
#(
    parameter int OPERAND_BITS = 31
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  operand_t first_operand,
    input  operand_t second_operand,
    output logic     out_valid,
    input  logic     out_stall,
    output coeff_t   coeff_first,
    output coeff_t   coeff_second,
    output gcd_t     common_divisor
);

    localparam int W   = OPERAND_BITS;
    localparam int EXT = (W > IN_W) ? W : IN_W;
    localparam int QE  = (W > COEFF_W) ? W : COEFF_W;
    localparam int GE  = (W > GCD_W) ? W : GCD_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_MULX   = 3'd3;
    localparam logic [2:0] S_MULY   = 3'd4;
    localparam logic [2:0] S_UPD    = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]   state_reg;
    logic [2:0]   state_next;

    logic [W-1:0] r_prev_reg;
    logic [W-1:0] r_cur_reg;
    coeff_t       xp_reg;
    coeff_t       yp_reg;
    coeff_t       xc_reg;
    coeff_t       yc_reg;
    coeff_t       x_new_reg;
    coeff_t       prod_reg;

    coeff_t       coeff_first_reg;
    coeff_t       coeff_second_reg;
    gcd_t         gcd_reg;
    logic         out_valid_reg;

    logic [EXT-1:0] a_ext;
    logic [EXT-1:0] b_ext;
    logic [QE-1:0]  q_ext;
    logic [GE-1:0]  g_ext;
    coeff_t         q32;
    coeff_t         mul_b;
    logic [2*COEFF_W-1:0] mul_full;

    logic         div_start;
    logic         div_busy;
    logic [W-1:0] div_quot;
    logic [W-1:0] div_rem;

    logic         accept;
    logic         load_out;

    ebz_div #(
        .W (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (r_prev_reg),
        .divisor   (r_cur_reg),
        .busy      (div_busy),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign a_ext = EXT'(first_operand);
    assign b_ext = EXT'(second_operand);

    // coefficients are only kept mod 2^32, so the low quotient bits suffice
    assign q_ext    = QE'(div_quot);
    assign q32      = q_ext[COEFF_W-1:0];
    assign mul_b    = (state_reg == S_MULX) ? xc_reg : yc_reg;
    assign mul_full = q32 * mul_b;

    assign g_ext = GE'(r_prev_reg);

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign div_start = (state_reg == S_CHECK) && (r_cur_reg != '0);
    assign load_out  = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = (r_cur_reg == '0) ? S_FINISH : S_DIV;
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = S_MULX;
                end
            end
            S_MULX:   state_next = S_MULY;
            S_MULY:   state_next = S_UPD;
            S_UPD:    state_next = S_CHECK;
            S_FINISH:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            r_prev_reg <= b_ext[W-1:0];
            r_cur_reg  <= a_ext[W-1:0];
            xp_reg     <= '0;
            yp_reg     <= COEFF_W'(1);
            xc_reg     <= COEFF_W'(1);
            yc_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_MULX:
                begin
                    prod_reg <= mul_full[COEFF_W-1:0];
                end
                S_MULY:
                begin
                    x_new_reg <= xp_reg - prod_reg;
                    prod_reg  <= mul_full[COEFF_W-1:0];
                end
                S_UPD:
                begin
                    r_prev_reg <= r_cur_reg;
                    r_cur_reg  <= div_rem;
                    xp_reg     <= xc_reg;
                    yp_reg     <= yc_reg;
                    xc_reg     <= x_new_reg;
                    yc_reg     <= yp_reg - prod_reg;
                end
                default:
                begin
                end
            endcase
        end

        if (load_out)
        begin
            coeff_first_reg  <= xp_reg;
            coeff_second_reg <= yp_reg;
            gcd_reg          <= g_ext[GCD_W-1:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign coeff_first    = coeff_first_reg;
    assign coeff_second   = coeff_second_reg;
    assign common_divisor = gcd_reg;

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_CHECK))
        else $error("request accepted but sequencer did not start");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (r_cur_reg != '0))
        else $error("divide started with zero divisor");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_DIV) |-> !div_busy)
        else $error("divider busy outside divide phase");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> (div_rem < r_cur_reg))
        else $error("remainder not below divisor");

endmodule

// File: bench/testbench.sv
// Self-checking bench for the extended GCD block: directed corner rows, then random operand pairs.
module testbench;
    import ebz_pkg::*;

    localparam int OPERAND_BITS = 31;
    localparam operand_t OP_MAX = 31'h7FFF_FFFF;
    localparam int RANDOM_REQUESTS = 1080;
    localparam int DRAIN_CYCLES = 2000;

    typedef struct packed {
        coeff_t x;
        coeff_t y;
        gcd_t   g;
    } bezout_t;

    typedef struct packed {
        operand_t a;
        operand_t b;
        logic     typed;
        bezout_t  want;
    } vector_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    operand_t first_operand;
    operand_t second_operand;
    logic     out_valid;
    logic     out_stall;
    coeff_t   coeff_first;
    coeff_t   coeff_second;
    gcd_t     common_divisor;

    bezout_t     pending_bezout[$];
    vector_row_t vectors[$];
    int          mismatches = 0;
    int          requests_sent = 0;
    int          results_checked = 0;
    int          longest_chain = 0;
    bit          steady = 1'b0;

    extended_gcd_bezout_top #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .first_operand (first_operand),
        .second_operand(second_operand),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .coeff_first   (coeff_first),
        .coeff_second  (coeff_second),
        .common_divisor(common_divisor)
    );

    always #5 clk = ~clk;

    // Forward Euclid on the pair (b, a), coefficients kept mod 2^64.
    function automatic bezout_t bezout_of(input operand_t a, input operand_t b,
                                          output int steps);
        logic [63:0] mask;
        logic [63:0] r_prev, r_cur, r_next, q;
        logic [63:0] xp, yp, xc, yc, x_next, y_next;
        bezout_t res;
        mask = (OPERAND_BITS >= 64) ? '1 : ((64'd1 << OPERAND_BITS) - 64'd1);
        r_prev = {33'b0, b} & mask;
        r_cur = {33'b0, a} & mask;
        xp = 64'd0;
        yp = 64'd1;
        xc = 64'd1;
        yc = 64'd0;
        steps = 0;
        while (r_cur != 64'd0) begin
            q = r_prev / r_cur;
            r_next = r_prev - q * r_cur;
            x_next = xp - q * xc;
            y_next = yp - q * yc;
            r_prev = r_cur;
            r_cur = r_next;
            xp = xc;
            yp = yc;
            xc = x_next;
            yc = y_next;
            steps++;
        end
        res.x = xp[COEFF_W-1:0];
        res.y = yp[COEFF_W-1:0];
        res.g = r_prev[GCD_W-1:0];
        return res;
    endfunction

    function automatic vector_row_t row(input operand_t a, input operand_t b, input logic typed,
                                        input coeff_t x, input coeff_t y, input gcd_t g);
        vector_row_t r;
        r.a = a;
        r.b = b;
        r.typed = typed;
        r.want.x = x;
        r.want.y = y;
        r.want.g = g;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one; none during steady stretches.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input operand_t a, input operand_t b, input bezout_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        first_operand <= a;
        second_operand <= b;
        do @(posedge clk); while (in_stall);
        pending_bezout.push_back(want);
        requests_sent++;
    endtask

    task automatic drain_requests();
        in_valid <= 1'b0;
        while (pending_bezout.size() != 0) @(posedge clk);
    endtask

    task automatic random_pair(output operand_t a, output operand_t b);
        logic [31:0] fa, fb, t;
        int width;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                a = operand_t'($urandom);
                b = operand_t'($urandom);
            end
            4, 5: begin
                a = operand_t'($urandom_range(0, 1000));
                b = operand_t'($urandom_range(0, 1000));
            end
            6: begin
                // shared factor so the gcd is large
                t = $urandom_range(1, 65535);
                a = operand_t'(t * $urandom_range(0, 32767));
                b = operand_t'(t * $urandom_range(0, 32767));
            end
            7: begin
                a = operand_t'($urandom);
                case ($urandom_range(0, 2))
                    0: b = 31'd0;
                    1: b = a;
                    default: begin
                        b = a;
                        a = 31'd0;
                    end
                endcase
            end
            8: begin
                // consecutive Fibonacci numbers give the longest chains
                fa = 32'd1;
                fb = 32'd1;
                repeat ($urandom_range(1, 44)) begin
                    t = fa + fb;
                    fa = fb;
                    fb = t;
                end
                if ($urandom_range(0, 1)) begin
                    a = operand_t'(fa);
                    b = operand_t'(fb);
                end else begin
                    a = operand_t'(fb);
                    b = operand_t'(fa);
                end
            end
            default: begin
                width = $urandom_range(1, 31);
                a = operand_t'($urandom) & ((31'd1 << width) - 31'd1);
                width = $urandom_range(1, 31);
                b = operand_t'($urandom) & ((31'd1 << width) - 31'd1);
            end
        endcase
    endtask

    initial begin : request_side
        operand_t a, b;
        bezout_t want;
        int steps;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        first_operand <= '0;
        second_operand <= '0;

        vectors.push_back(row(31'd0, 31'd0, 1'b1, 32'd0, 32'd1, 31'd0));
        vectors.push_back(row(31'd0, OP_MAX, 1'b1, 32'd0, 32'd1, OP_MAX));
        vectors.push_back(row(OP_MAX, 31'd0, 1'b1, 32'd1, 32'd0, OP_MAX));
        vectors.push_back(row(31'd0, 31'd1, 1'b1, 32'd0, 32'd1, 31'd1));
        vectors.push_back(row(31'd1, 31'd0, 1'b1, 32'd1, 32'd0, 31'd1));
        vectors.push_back(row(31'd1, 31'd1, 1'b1, 32'd1, 32'd0, 31'd1));
        vectors.push_back(row(OP_MAX, OP_MAX, 1'b1, 32'd1, 32'd0, OP_MAX));
        vectors.push_back(row(31'd7, 31'd7, 1'b1, 32'd1, 32'd0, 31'd7));
        vectors.push_back(row(31'd1, OP_MAX, 1'b1, 32'd1, 32'd0, 31'd1));
        vectors.push_back(row(OP_MAX, 31'd1, 1'b0, '0, '0, '0));
        vectors.push_back(row(31'd1134903170, 31'd1836311903, 1'b0, '0, '0, '0));
        vectors.push_back(row(31'd1836311903, 31'd1134903170, 1'b0, '0, '0, '0));
        vectors.push_back(row(OP_MAX, OP_MAX - 31'd1, 1'b0, '0, '0, '0));
        vectors.push_back(row(OP_MAX - 31'd1, OP_MAX, 1'b0, '0, '0, '0));
        vectors.push_back(row(31'h4000_0000, 31'h2000_0000, 1'b0, '0, '0, '0));
        vectors.push_back(row(31'h5555_5555, 31'h2AAA_AAAA, 1'b0, '0, '0, '0));
        vectors.push_back(row(31'h2AAA_AAAA, 31'h5555_5555, 1'b0, '0, '0, '0));
        vectors.push_back(row(31'd12, 31'd18, 1'b0, '0, '0, '0));
        vectors.push_back(row(31'd240, 31'd46, 1'b0, '0, '0, '0));
        vectors.push_back(row(31'd2147483629, OP_MAX, 1'b0, '0, '0, '0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i]) begin
            want = bezout_of(vectors[i].a, vectors[i].b, steps);
            if (steps > longest_chain)
                longest_chain = steps;
            if (vectors[i].typed)
                want = vectors[i].want;
            send_request(vectors[i].a, vectors[i].b, want);
        end
        drain_requests();

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            steady = ((i / 150) % 4 == 3);
            if (i % 250 == 249)
                drain_requests();
            random_pair(a, b);
            want = bezout_of(a, b, steps);
            if (steps > longest_chain)
                longest_chain = steps;
            send_request(a, b, want);
        end
        steady = 1'b0;
        drain_requests();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d directed rows, rest random pairs incl. Fibonacci runs),",
                 requests_sent, vectors.size());
        $display("checked %0d results; longest Euclid chain %0d steps, %0d mismatches.",
                 results_checked, longest_chain, mismatches);
        if (mismatches == 0 && pending_bezout.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : result_side
        int hold;
        bezout_t want;
        hold = 0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                results_checked++;
                if (pending_bezout.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result with no request pending: x=%0d y=%0d g=%0d",
                                 $signed(coeff_first), $signed(coeff_second), common_divisor);
                end else begin
                    want = pending_bezout.pop_front();
                    if (coeff_first !== want.x || coeff_second !== want.y
                        || common_divisor !== want.g) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result %0d expected x=%0d y=%0d g=%0d, got x=%0d y=%0d g=%0d",
                                     results_checked, $signed(want.x), $signed(want.y), want.g,
                                     $signed(coeff_first), $signed(coeff_second), common_divisor);
                    end
                end
            end
            if (hold > 0) begin
                hold--;
                out_stall <= 1'b1;
            end else begin
                hold = pick_gap();
                out_stall <= (hold > 0);
                if (hold > 0)
                    hold--;
            end
        end
    end

    initial begin : watchdog
        #100_000_000;
        $display("Timeout with %0d results outstanding", pending_bezout.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
